// ===== sv/ppu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool update package
// Shared widths, the particle record, the sequencer states and the saturating vector add.
// ----------------------------------------------------------------------------
package ppu_pkg;

  localparam int MAX_PARTICLES_DEF = 64;
  localparam int VEC_W   = 48;
  localparam int LIFE_W  = 16;
  localparam int SCALE_W = 16;
  localparam int COLOR_W = 32;
  localparam int LIVE_W  = 7;
  localparam int DROP_W  = 16;
  localparam int FRAC_W  = 16;
  localparam int IN_W    = 256;
  localparam int OUT_W   = 120;

  typedef struct packed {
    logic [VEC_W-1:0]     pos;
    logic [VEC_W-1:0]     vel;
    logic [VEC_W-1:0]     acc;
    logic [LIFE_W-1:0]    age;
    logic [LIFE_W-1:0]    life;
    logic [2*SCALE_W-1:0] scale_pair;
    logic [2*COLOR_W-1:0] color_pair;
  } particle_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD,
    ST_CWR,
    ST_URD,
    ST_ULD,
    ST_UPOS,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_e;

  function automatic logic [VEC_W-1:0] vec_add_sat(logic [VEC_W-1:0] a,
                                                   logic [VEC_W-1:0] b);
    logic [VEC_W-1:0] r;
    logic signed [16:0] s;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      s = 17'(signed'(a[16*i +: 16])) + 17'(signed'(b[16*i +: 16]));
      if (s > 17'sd32767) begin
        r[16*i +: 16] = 16'h7fff;
      end else if (s < -17'sd32768) begin
        r[16*i +: 16] = 16'h8000;
      end else begin
        r[16*i +: 16] = s[15:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/ppu_frac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Age over life fraction unit
// Restoring divider, one quotient bit per cycle, giving age * 65536 / life
// capped at 65535. Requires 1 <= age <= life.
// ----------------------------------------------------------------------------
module ppu_frac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ppu_pkg::LIFE_W-1:0] age_i,
  input  logic [ppu_pkg::LIFE_W-1:0] life_i,
  output logic                  done_o,
  output logic [ppu_pkg::FRAC_W-1:0] frac_o
);
  import ppu_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [4:0]        cnt_q;
  logic [LIFE_W-1:0] rem_q;
  logic [LIFE_W-1:0] div_q;
  logic [FRAC_W-1:0] quo_q;
  logic              full_q;
  logic [LIFE_W:0]   rem2;

  assign rem2 = {rem_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd16;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= age_i;
      div_q  <= life_i;
      quo_q  <= '0;
      full_q <= (age_i == life_i);
    end else if (busy_q) begin
      if (rem2 >= {1'b0, div_q}) begin
        rem_q <= LIFE_W'(rem2 - {1'b0, div_q});
        quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
      end else begin
        rem_q <= rem2[LIFE_W-1:0];
        quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign frac_o = full_q ? {FRAC_W{1'b1}} : quo_q;

endmodule

// ===== sv/particle_pool_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool update
// Particle store with add, expiry compaction and per-tick Euler update.
// ----------------------------------------------------------------------------
// An add item is written into the pool, or counted as dropped when the pool is
// full. A tick item first compacts the pool, reading each stored particle and
// writing back the survivors, then takes each survivor in turn through a
// memory read and load, the saturating position update, a wait on the
// bit-serial divider for age over life, five passes (a multiply and an
// accumulate step each) through the one shared multiplier for scale and the
// four color channels, and the output handshake, which can stall. The input
// side is ready only between items.
module particle_pool_update #(
  parameter int MAX_PARTICLES = ppu_pkg::MAX_PARTICLES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // life, start_position, start_velocity, acceleration, scale_begin,
  // scale_end, color_begin, color_end
  input  logic [ppu_pkg::IN_W-1:0]   s_axis_tdata,
  // operation
  input  logic                       s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // vertex_position, vertex_scale, vertex_color, live_total, adds_dropped, pad
  output logic [ppu_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,
  // pool_empty
  output logic                       m_axis_tuser
);
  import ppu_pkg::*;

  localparam int IdxW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CntW = $clog2(MAX_PARTICLES + 1);

  particle_t mem [MAX_PARTICLES];
  particle_t rd_data_q;
  particle_t rec_q;
  particle_t ld_rec;
  particle_t in_rec;
  particle_t wr_data;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;

  state_e state_q, state_d;
  logic [CntW-1:0]   live_q, rd_idx_q, wr_idx_q, k_q;
  logic [DROP_W-1:0] drop_q;
  logic [FRAC_W-1:0] frac_q;
  logic [2:0]        mix_q;
  logic signed [34:0] prod_q;
  logic [SCALE_W-1:0] scale_q;
  logic [COLOR_W-1:0] color_q;

  logic              out_valid_q;
  logic [VEC_W-1:0]  o_pos_q;
  logic [SCALE_W-1:0] o_scale_q;
  logic [COLOR_W-1:0] o_color_q;
  logic              o_last_q, o_empty_q;
  logic [LIVE_W-1:0] o_live_q;
  logic [DROP_W-1:0] o_drop_q;

  logic in_acc, is_add, full, alive, div_start, div_done;
  logic [FRAC_W-1:0] div_frac;
  logic [VEC_W-1:0]  new_pos;
  logic [15:0] mix_b, mix_e;
  logic signed [16:0] mix_d;
  logic signed [18:0] mix_val;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign is_add = !s_axis_tuser;
  assign full   = (live_q >= CntW'(MAX_PARTICLES));
  assign alive  = rd_data_q.age < rd_data_q.life;
  assign new_pos = vec_add_sat(rec_q.pos, rec_q.vel);

  always_comb begin
    in_rec.life       = s_axis_tdata[15:0];
    in_rec.pos        = s_axis_tdata[63:16];
    in_rec.vel        = s_axis_tdata[111:64];
    in_rec.acc        = s_axis_tdata[159:112];
    in_rec.scale_pair = s_axis_tdata[191:160];
    in_rec.color_pair = s_axis_tdata[255:192];
    in_rec.age        = '0;
  end

  always_comb begin
    ld_rec     = rd_data_q;
    ld_rec.age = rd_data_q.age + 1'b1;
    ld_rec.vel = vec_add_sat(rd_data_q.vel, rd_data_q.acc);
  end

  always_comb begin
    mix_b = '0;
    mix_e = '0;
    case (mix_q)
      3'd0: begin
        mix_b = rec_q.scale_pair[15:0];
        mix_e = rec_q.scale_pair[31:16];
      end
      3'd1: begin
        mix_b = {8'd0, rec_q.color_pair[7:0]};
        mix_e = {8'd0, rec_q.color_pair[39:32]};
      end
      3'd2: begin
        mix_b = {8'd0, rec_q.color_pair[15:8]};
        mix_e = {8'd0, rec_q.color_pair[47:40]};
      end
      3'd3: begin
        mix_b = {8'd0, rec_q.color_pair[23:16]};
        mix_e = {8'd0, rec_q.color_pair[55:48]};
      end
      default: begin
        mix_b = {8'd0, rec_q.color_pair[31:24]};
        mix_e = {8'd0, rec_q.color_pair[63:56]};
      end
    endcase
  end

  assign mix_d   = signed'({1'b0, mix_e}) - signed'({1'b0, mix_b});
  assign mix_val = signed'({3'b0, mix_b}) + 19'(prod_q >>> 16);

  ppu_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .age_i   (rec_q.age),
    .life_i  (rec_q.life),
    .done_o  (div_done),
    .frac_o  (div_frac)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && !is_add) state_d = ST_CRD;
      ST_CRD: begin
        if (rd_idx_q == live_q) begin
          state_d = (wr_idx_q == '0) ? ST_EMIT : ST_URD;
        end else begin
          state_d = ST_CWR;
        end
      end
      ST_CWR:  state_d = ST_CRD;
      ST_URD:  state_d = ST_ULD;
      ST_ULD:  state_d = ST_UPOS;
      ST_UPOS: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = (mix_q == 3'd4) ? ST_EMIT : ST_MUL;
      ST_EMIT: begin
        if (m_axis_tready) state_d = (k_q == '0) ? ST_IDLE : ST_URD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = live_q[IdxW-1:0];
    wr_data   = in_rec;
    rd_addr   = rd_idx_q[IdxW-1:0];
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en = in_acc && is_add && !full;
      end
      ST_CWR: begin
        wr_en   = alive;
        wr_addr = wr_idx_q[IdxW-1:0];
        wr_data = rd_data_q;
      end
      ST_URD: rd_addr = k_q[IdxW-1:0];
      ST_UPOS: begin
        wr_en     = 1'b1;
        wr_addr   = k_q[IdxW-1:0];
        wr_data   = rec_q;
        wr_data.pos = new_pos;
        div_start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      drop_q      <= '0;
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      k_q         <= '0;
      mix_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && is_add) begin
            if (full) begin
              if (drop_q != {DROP_W{1'b1}}) drop_q <= drop_q + 1'b1;
            end else begin
              live_q <= live_q + 1'b1;
            end
          end
          rd_idx_q <= '0;
          wr_idx_q <= '0;
        end
        ST_CRD: begin
          if (rd_idx_q == live_q) begin
            live_q <= wr_idx_q;
            k_q    <= (wr_idx_q == '0) ? '0 : wr_idx_q - 1'b1;
            if (wr_idx_q == '0) out_valid_q <= 1'b1;
          end
        end
        ST_CWR: begin
          rd_idx_q <= rd_idx_q + 1'b1;
          if (alive) wr_idx_q <= wr_idx_q + 1'b1;
        end
        ST_DIV: mix_q <= '0;
        ST_ACC: begin
          if (mix_q == 3'd4) begin
            out_valid_q <= 1'b1;
          end else begin
            mix_q <= mix_q + 3'd1;
          end
        end
        ST_EMIT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            if (k_q != '0) k_q <= k_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CRD: begin
        o_pos_q   <= '0;
        o_scale_q <= '0;
        o_color_q <= '0;
        o_last_q  <= 1'b1;
        o_empty_q <= 1'b1;
        o_live_q  <= '0;
        o_drop_q  <= drop_q;
      end
      ST_ULD:  rec_q <= ld_rec;
      ST_UPOS: rec_q.pos <= new_pos;
      ST_DIV:  if (div_done) frac_q <= div_frac;
      ST_MUL:  prod_q <= 35'(mix_d * signed'({2'b0, frac_q}));
      ST_ACC: begin
        if (mix_q == 3'd0) begin
          scale_q <= mix_val[15:0];
        end else begin
          color_q[8*(mix_q-3'd1) +: 8] <= mix_val[7:0];
        end
        if (mix_q == 3'd4) begin
          o_pos_q   <= rec_q.pos;
          o_scale_q <= scale_q;
          o_color_q <= {mix_val[7:0], color_q[23:0]};
          o_last_q  <= (k_q == '0);
          o_empty_q <= 1'b0;
          o_live_q  <= LIVE_W'(live_q);
          o_drop_q  <= drop_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, o_drop_q, o_live_q, o_color_q, o_scale_q, o_pos_q};
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tuser  = o_empty_q;

endmodule

// ===== sv/ppu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool update port checker
// Concurrent checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ppu_pkg::OUT_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast,
  input logic                      m_axis_tuser
);
  import ppu_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output item changed while stalled.");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("Input ready while an output item is pending.");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[102:0] == '0)
    else $error("Empty item is not a zero last item.");

  a_live_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[102:96] != '0)
    else $error("Vertex item reports no live particles.");

endmodule

bind particle_pool_update ppu_chk u_ppu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_particle_pool_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pool update testbench
// Drives add and tick items into the particle pool and checks every emitted
// vertex against a behavioral copy of the pool, field by field, in order.
// ----------------------------------------------------------------------------
module tb_particle_pool_update;
  import ppu_pkg::*;

  localparam int NPART = 64;

  typedef struct {
    logic [VEC_W-1:0]   pos;
    logic [SCALE_W-1:0] scale;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               empty;
    logic [LIVE_W-1:0]  live;
    logic [DROP_W-1:0]  dropped;
  } vertex_t;

  class vertex_scoreboard;
    particle_t pool[$];
    int unsigned drops;
    vertex_t expected_q[$];
    int errors;
    int vertices;

    function logic [VEC_W-1:0] sat_add(logic [VEC_W-1:0] a, logic [VEC_W-1:0] b);
      logic [VEC_W-1:0] r;
      int s;
      for (int i = 0; i < 3; i++) begin
        s = int'($signed(a[16*i +: 16])) + int'($signed(b[16*i +: 16]));
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        r[16*i +: 16] = s[15:0];
      end
      return r;
    endfunction

    function longint unsigned blend(longint unsigned b, longint unsigned e,
                                    longint unsigned f);
      return (b * (65536 - f) + e * f) >> 16;
    endfunction

    function void note_item(logic op, logic [IN_W-1:0] d);
      particle_t p;
      particle_t kept[$];
      vertex_t v;
      longint unsigned f;
      int n;
      if (!op) begin
        if (pool.size() >= NPART) begin
          if (drops < 65535) drops++;
          return;
        end
        p.life = d[15:0];
        p.pos = d[63:16];
        p.vel = d[111:64];
        p.acc = d[159:112];
        p.scale_pair = d[191:160];
        p.color_pair = d[255:192];
        p.age = '0;
        pool.push_back(p);
        return;
      end
      foreach (pool[i]) if (pool[i].age < pool[i].life) kept.push_back(pool[i]);
      pool = kept;
      n = pool.size();
      if (n == 0) begin
        v = '{pos: '0, scale: '0, color: '0, last: 1'b1, empty: 1'b1, live: '0,
              dropped: drops[15:0]};
        expected_q.push_back(v);
        return;
      end
      foreach (pool[i]) begin
        pool[i].age = pool[i].age + 1;
        pool[i].vel = sat_add(pool[i].vel, pool[i].acc);
        pool[i].pos = sat_add(pool[i].pos, pool[i].vel);
      end
      for (int i = n - 1; i >= 0; i--) begin
        f = (longint'(pool[i].age) << 16) / pool[i].life;
        if (f > 65535) f = 65535;
        v.pos = pool[i].pos;
        v.scale = 16'(blend(pool[i].scale_pair[15:0], pool[i].scale_pair[31:16], f));
        for (int c = 0; c < 4; c++)
          v.color[8*c +: 8] = 8'(blend(pool[i].color_pair[8*c +: 8],
                                       pool[i].color_pair[32+8*c +: 8], f));
        v.last = (i == 0);
        v.empty = 1'b0;
        v.live = 7'(n);
        v.dropped = drops[15:0];
        expected_q.push_back(v);
      end
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      vertices++;
      if (expected_q.size() == 0) begin
        $error("unexpected vertex result");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.pos !== e.pos) begin
        $error("vertex_position exp %h got %h", e.pos, a.pos); errors++;
      end
      if (a.scale !== e.scale) begin
        $error("vertex_scale exp %h got %h", e.scale, a.scale); errors++;
      end
      if (a.color !== e.color) begin
        $error("vertex_color exp %h got %h", e.color, a.color); errors++;
      end
      if (a.last !== e.last) begin
        $error("last_of_run exp %b got %b", e.last, a.last); errors++;
      end
      if (a.empty !== e.empty) begin
        $error("pool_empty exp %b got %b", e.empty, a.empty); errors++;
      end
      if (a.live !== e.live) begin
        $error("live_total exp %0d got %0d", e.live, a.live); errors++;
      end
      if (a.dropped !== e.dropped) begin
        $error("adds_dropped exp %0d got %0d", e.dropped, a.dropped); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic m_axis_tuser;

  vertex_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  bit hold_sink = 1'b0;
  int adds_sent, ticks_sent;

  always #2 clk_i = ~clk_i;

  particle_pool_update DUT (.*);

  task automatic send_item(logic op, logic [IN_W-1:0] d);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, d);
    if (op) ticks_sent++; else adds_sent++;
  endtask

  function automatic logic [IN_W-1:0] rand_add(logic [15:0] life);
    logic [IN_W-1:0] d;
    for (int i = 0; i < IN_W / 32; i++) d[32*i +: 32] = $urandom();
    d[15:0] = life;
    return d;
  endfunction

  task automatic add_particle(logic [15:0] life);
    send_item(1'b0, rand_add(life));
  endtask

  task automatic tick();
    send_item(1'b1, rand_add(16'($urandom())));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_vertex('{pos: m_axis_tdata[47:0], scale: m_axis_tdata[63:48],
                        color: m_axis_tdata[95:64], last: m_axis_tlast,
                        empty: m_axis_tuser, live: m_axis_tdata[102:96],
                        dropped: m_axis_tdata[118:103]});
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_sink = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [IN_W-1:0] d;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tick();
    add_particle(16'd0);
    add_particle(16'd1);
    add_particle(16'hffff);
    d = '1;
    send_item(1'b0, d);
    d = '0;
    d[15:0] = 16'd3;
    d[63:16] = {16'h7fff, 16'h8000, 16'h7fff};
    d[111:64] = {16'h7fff, 16'h8000, 16'h7fff};
    d[159:112] = {16'h7fff, 16'h8000, 16'h7fff};
    d[255:192] = 64'hffffffff_00000000;
    d[191:160] = 32'hffff_0000;
    send_item(1'b0, d);
    repeat (4) tick();
    drain();
    // fill the pool beyond capacity, then hold off the output during the ticks
    for (int i = 0; i < NPART + 3; i++) add_particle(16'($urandom_range(1, 6)));
    hold_sink = 1'b1;
    tick();
    tick();
    drain();
    for (int i = 0; i < 90; i++) begin
      if (i == 70) quiet_phase = 1'b1;
      if ($urandom_range(0, 3) == 0) tick();
      else add_particle($urandom_range(0, 3) == 0 ? 16'($urandom()) :
                        16'($urandom_range(0, 8)));
    end
    tick();
    drain();
    $display("Sent %0d adds and %0d ticks; checked %0d vertices.", adds_sent,
             ticks_sent, sb.vertices);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== particle_pool_update.f =====
sv/ppu_pkg.sv
sv/ppu_frac.sv
sv/particle_pool_update.sv
sv/ppu_chk.sv
test/tb_particle_pool_update.sv
